// File: sv/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg - shared types and constants for the coupon collector trial block
// Widths, generator constants and the remainder step used by the mod-N pipe.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int SEED_W     = 63;   // trial seed width
  localparam int GEN_W      = 31;   // generator state width
  localparam int DRAW_W     = 32;   // draw_count field width
  localparam int COUNT_BITS = 32;   // internal draw counter width
  localparam int MAX_KINDS  = 64;   // widest collected mask
  localparam int CFG_W      = 7;    // n_kinds register width
  localparam int KIND_W     = $clog2(MAX_KINDS);
  localparam int NK_W       = $clog2(MAX_KINDS + 1);

  // mod-N pipe: value padded to PAD_W bits, CHUNK_W bits per stage
  localparam int CHUNK_W    = 8;
  localparam int PAD_W      = 32;
  localparam int MOD_STAGES = PAD_W / CHUNK_W;

  localparam logic [CFG_W-1:0]      N_KINDS_RST   = CFG_W'(10);
  localparam logic [14:0]           LEHMER_MULT   = 15'd16807;
  localparam logic [GEN_W-1:0]      LEHMER_MOD    = 31'h7FFF_FFFF;
  localparam logic [GEN_W-1:0]      ZERO_SEED_SUB = 31'h7FFF_FFFE;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};

  // One drawn kind leaving the mod-N pipe
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
  } cct_draw_t;

  // Eight restoring remainder steps: (rem * 2^8 + chunk) mod n, rem < n
  function automatic logic [KIND_W-1:0] rem_chunk(input logic [KIND_W-1:0]  rem,
                                                  input logic [CHUNK_W-1:0] chunk,
                                                  input logic [NK_W-1:0]    n);
    logic [KIND_W:0] r;
    r = {1'b0, rem};
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      r = {r[KIND_W-1:0], chunk[i]};
      if (r >= (KIND_W + 1)'(n)) begin
        r = r - (KIND_W + 1)'(n);
      end
    end
    return r[KIND_W-1:0];
  endfunction

endpackage

// File: sv/cct_if.sv
// ----------------------------------------------------------------------------
// cct_if - request channels of the coupon collector trial block
// Seed channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_in_if import cct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] trial_seed;

  modport source (output valid, output trial_seed, input ready);
  modport sink   (input valid, input trial_seed, output ready);
endinterface

interface cct_out_if import cct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] draw_count;
  logic              count_saturated;

  modport source (output valid, output draw_count, output count_saturated, input ready);
  modport sink   (input valid, input draw_count, input count_saturated, output ready);
endinterface

// File: sv/cct_mod_pipe.sv
// ----------------------------------------------------------------------------
// cct_mod_pipe - generator value mod N, one value per cycle
// Restoring remainder, one byte of the value per stage; flush drops all.
// ----------------------------------------------------------------------------
module cct_mod_pipe import cct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [GEN_W-1:0] in_value,
  input  logic [NK_W-1:0]  n_kinds,
  input  logic             flush,
  output cct_draw_t        draw
);

  logic [MOD_STAGES-1:0]             val_r, val_nxt;
  logic [KIND_W-1:0]                 rem_r [MOD_STAGES];
  logic [KIND_W-1:0]                 rem_nxt [MOD_STAGES];
  logic [PAD_W-1:0]                  rest_r [MOD_STAGES];
  logic [PAD_W-1:0]                  rest_nxt [MOD_STAGES];
  logic [PAD_W-1:0]                  in_pad;

  assign in_pad = PAD_W'(in_value);

  always_comb begin
    val_nxt[0]  = in_valid && !flush;
    rem_nxt[0]  = rem_chunk('0, in_pad[PAD_W-1 -: CHUNK_W], n_kinds);
    rest_nxt[0] = in_pad << CHUNK_W;
    for (int k = 1; k < MOD_STAGES; k++) begin
      val_nxt[k]  = val_r[k-1] && !flush;
      rem_nxt[k]  = rem_chunk(rem_r[k-1], rest_r[k-1][PAD_W-1 -: CHUNK_W], n_kinds);
      rest_nxt[k] = rest_r[k-1] << CHUNK_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
    for (int k = 0; k < MOD_STAGES; k++) begin
      rem_r[k]  <= rem_nxt[k];
      rest_r[k] <= rest_nxt[k];
    end
  end

  assign draw.valid = val_r[MOD_STAGES-1];
  assign draw.kind  = rem_r[MOD_STAGES-1];

endmodule

// File: sv/coupon_collector_trial_top.sv
// ----------------------------------------------------------------------------
// coupon_collector_trial_top - one coupon collector trial per seed request
// MINSTD Lehmer draws, kind = state mod N, count draws until all N are seen or the count saturates.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake               payload
//   in_chan   in   valid/ready             trial_seed [62:0]
//   out_chan  out  valid/ready             draw_count [31:0], count_saturated
//   cfg_*     in   cfg_we (no wait)        cfg_wdata [6:0] -> n_kinds
//
// Steps: seed reduction folds the seed's high part onto its low 31 bits through
//   the shared adder, then the Lehmer unit makes one draw per cycle; each draw
//   passes the mod-N pipe and then the mask/counter stage.
// Reset: synchronous, active low; n_kinds returns to 10, the block to idle.
// Stalls: in_chan.ready is high only when idle. A finished result goes to the
//   output register; if that is still full the block waits holding its count.
//
module coupon_collector_trial_top import cct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  cct_in_if.sink             in_chan,
  cct_out_if.source          out_chan,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FOLD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_WAIT = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      n_kinds_r;
  logic [SEED_W-1:0]     acc_r, acc_nxt;        // seed being folded mod 2^31-1
  logic [GEN_W-1:0]      gen_r, gen_nxt;        // generator state
  logic                  gen_v_r, gen_v_nxt;    // gen_r holds a fresh draw
  logic [MAX_KINDS-1:0]  mask_r, mask_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  sat_r, sat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DRAW_W-1:0]     out_count_r, out_count_nxt;
  logic                  out_sat_r, out_sat_nxt;

  logic [NK_W-1:0]       n_eff;
  logic [MAX_KINDS-1:0]  full_mask;
  logic [45:0]           prod;
  logic [31:0]           fold_a;
  logic [GEN_W-1:0]      fold_b;
  logic [32:0]           fold_sum;
  logic [32:0]           fold_red;
  logic                  in_acc;
  logic                  out_free;
  cct_draw_t             draw;
  logic                  take;
  logic                  finish;
  logic [MAX_KINDS-1:0]  mask_hit;
  logic [COUNT_BITS-1:0] cnt_inc;

  // Effective kind count: zero acts as one, large values clamp to MAX_KINDS
  always_comb begin
    if (n_kinds_r == '0) begin
      n_eff = NK_W'(1);
    end else if (n_kinds_r > CFG_W'(MAX_KINDS)) begin
      n_eff = NK_W'(MAX_KINDS);
    end else begin
      n_eff = NK_W'(n_kinds_r);
    end
    if (n_eff >= NK_W'(MAX_KINDS)) begin
      full_mask = '1;
    end else begin
      full_mask = (MAX_KINDS'(1) << n_eff) - MAX_KINDS'(1);
    end
  end

  // Shared Mersenne fold: hi + lo, then one subtract of 2^31-1.
  // FOLD reduces the seed, RUN reduces 16807 * state.
  assign prod = 46'(gen_r) * 46'(LEHMER_MULT);

  always_comb begin
    if (state_r == ST_FOLD) begin
      fold_a = acc_r[SEED_W-1:GEN_W];
      fold_b = acc_r[GEN_W-1:0];
    end else begin
      fold_a = 32'(prod[45:GEN_W]);
      fold_b = prod[GEN_W-1:0];
    end
    fold_sum = 33'(fold_a) + 33'(fold_b);
    if (fold_sum >= 33'(LEHMER_MOD)) begin
      fold_red = fold_sum - 33'(LEHMER_MOD);
    end else begin
      fold_red = fold_sum;
    end
  end

  cct_mod_pipe u_mod_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (gen_v_r),
    .in_value (gen_r),
    .n_kinds  (n_eff),
    .flush    (finish),
    .draw     (draw)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Mask/counter stage: one drawn kind per cycle while running
  assign mask_hit = mask_r | (MAX_KINDS'(1) << draw.kind);
  assign cnt_inc  = count_r + COUNT_BITS'(1);
  assign take     = (state_r == ST_RUN) && draw.valid;
  assign finish   = take && ((mask_hit == full_mask) || (cnt_inc == COUNT_MAX));

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    gen_nxt       = gen_r;
    gen_v_nxt     = 1'b0;
    mask_nxt      = mask_r;
    count_nxt     = count_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_count_nxt = out_count_r;
    out_sat_nxt   = out_sat_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          acc_nxt   = in_chan.trial_seed;
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (acc_r[SEED_W-1:GEN_W] == '0) begin
          // residue zero (seed bits zero or exactly 2^31-1) takes the substitute
          if (acc_r[GEN_W-1:0] == '0 || acc_r[GEN_W-1:0] == LEHMER_MOD) begin
            gen_nxt = ZERO_SEED_SUB;
          end else begin
            gen_nxt = acc_r[GEN_W-1:0];
          end
          mask_nxt  = '0;
          count_nxt = '0;
          state_nxt = ST_RUN;
        end else begin
          acc_nxt = SEED_W'(fold_sum);
        end
      end
      ST_RUN: begin
        gen_nxt   = fold_red[GEN_W-1:0];
        gen_v_nxt = !finish;
        if (take) begin
          mask_nxt  = mask_hit;
          count_nxt = cnt_inc;
        end
        if (finish) begin
          // last missing kind on the final count still counts as complete
          sat_nxt = (mask_hit != full_mask);
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = DRAW_W'(cnt_inc);
            out_sat_nxt   = (mask_hit != full_mask);
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = DRAW_W'(count_r);
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      n_kinds_r   <= N_KINDS_RST;
    end else begin
      state_r     <= state_nxt;
      gen_v_r     <= gen_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        n_kinds_r <= cfg_wdata;
      end
    end
    acc_r       <= acc_nxt;
    gen_r       <= gen_nxt;
    mask_r      <= mask_nxt;
    count_r     <= count_nxt;
    sat_r       <= sat_nxt;
    out_count_r <= out_count_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.draw_count      = out_count_r;
  assign out_chan.count_saturated = out_sat_r;

`ifndef SYNTH
  // generator never sits at zero or at the modulus while drawing
  a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (gen_r != '0 && gen_r != LEHMER_MOD))
    else $error("generator state out of range");

  // collected mask stays inside the active kinds
  a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((mask_r & ~full_mask) == '0))
    else $error("collected mask has a kind beyond N");

  // an accepted seed always goes to reduction
  a_accept_fold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_FOLD))
    else $error("accepted seed did not start reduction");

  // a trial waiting on the output keeps its count
  a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |=> $stable(count_r))
    else $error("draw count changed while waiting for output");

  // no draw enters the pipe on the cycle after a trial ends
  a_finish_stop: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (!gen_v_r && !draw.valid))
    else $error("draws still flowing after trial end");
`endif

endmodule
